@@ rtl/uvst_pkg.sv @@
`default_nettype none
package uvst_pkg;

  localparam int MAX_COUNT = 64;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int RAD_W     = 24;
  localparam int CRD_W     = 32;
  localparam int ANG_W     = 32;
  localparam int ITERS     = 30;
  localparam int CW        = 34;   // CORDIC x/y and sin/cos width
  localparam int RW        = 28;   // ring/height/product width
  localparam int PW        = RW + CW;
  localparam int NUNIT     = 4;    // lat lo, lat hi, col a, col c
  localparam int NPT       = 4;
  localparam int RCP_SH    = 20;
  localparam int NUM_W     = 13;

  localparam logic [CW-1:0]    CORDIC_GAIN = CW'(652032874);
  localparam logic [RAD_W-1:0] RADIUS_RST  = RAD_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0] COUNT_RST   = CNT_W'(16);
  localparam logic [ANG_W-1:0] QUARTER     = ANG_W'(1) << (ANG_W - 2);
  localparam logic signed [PW-1:0] RND_HALF = PW'(1) << 29;

  typedef enum logic [2:0] {
    REG_RADIUS = 3'd0,
    REG_COUNT  = 3'd1,
    REG_CX     = 3'd2,
    REG_CY     = 3'd3,
    REG_CZ     = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_BOTTOM,
    MODE_TOP,
    MODE_MID
  } patch_mode_t;

  // point ids: {lat hi, col c}
  localparam logic [1:0] PT_LO_A = 2'd0;
  localparam logic [1:0] PT_LO_C = 2'd1;
  localparam logic [1:0] PT_HI_A = 2'd2;
  localparam logic [1:0] PT_HI_C = 2'd3;

  localparam logic [2:0] LAST_CAP = 3'd2;
  localparam logic [2:0] LAST_MID = 3'd5;

  typedef struct packed {
    patch_mode_t mode;
    logic        pole_lo;
    logic        pole_hi;
  } side_t;

  typedef logic [NUNIT-1:0][ANG_W-1:0] ang_vec_t;
  typedef logic [NUNIT-1:0][CW-1:0]    cs_vec_t;

  typedef logic [31:0]       quot_tab_t [MAX_COUNT+1];
  typedef logic [CNT_W-1:0]  rem_tab_t  [MAX_COUNT+1];
  typedef logic [RCP_SH-1:0] rcp_tab_t  [MAX_COUNT+1];

  function automatic quot_tab_t make_quot(input int sh);
    quot_tab_t t;
    for (int d = 0; d <= MAX_COUNT; d++) begin
      if (d >= 2) t[d] = 32'((64'd1 << sh) / 64'(d));
      else t[d] = '0;
    end
    return t;
  endfunction

  function automatic rem_tab_t make_rem(input int sh);
    rem_tab_t t;
    for (int d = 0; d <= MAX_COUNT; d++) begin
      if (d >= 2) t[d] = CNT_W'((64'd1 << sh) % 64'(d));
      else t[d] = '0;
    end
    return t;
  endfunction

  function automatic rcp_tab_t make_rcp();
    rcp_tab_t t;
    for (int d = 0; d <= MAX_COUNT; d++) begin
      if (d >= 2) t[d] = RCP_SH'(((64'd1 << RCP_SH) + 64'(d) - 64'd1) / 64'(d));
      else t[d] = '0;
    end
    return t;
  endfunction

  localparam quot_tab_t Q_COL = make_quot(32);
  localparam quot_tab_t Q_LAT = make_quot(31);
  localparam rem_tab_t  R_COL = make_rem(32);
  localparam rem_tab_t  R_LAT = make_rem(31);
  localparam rcp_tab_t  RCP   = make_rcp();

  localparam logic [ANG_W-1:0] ATAN_TAB [ITERS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  // Q2.30 product, round half up, floor shift
  function automatic logic signed [RW-1:0] mul_q30(input logic signed [RW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    p = p + RND_HALF;
    return p[RW+29:30];
  endfunction

  function automatic logic [CRD_W-1:0] sat32(input logic signed [CRD_W+1:0] v);
    if (v[CRD_W+1:CRD_W-1] == 3'b000 || v[CRD_W+1:CRD_W-1] == 3'b111) begin
      return v[CRD_W-1:0];
    end
    return v[CRD_W+1] ? {1'b1, {(CRD_W-1){1'b0}}} : {1'b0, {(CRD_W-1){1'b1}}};
  endfunction

  function automatic logic [1:0] pt_sel(input patch_mode_t m, input logic [2:0] i);
    logic [1:0] r;
    r = PT_LO_A;
    unique case (m)
      MODE_BOTTOM: begin
        case (i)
          3'd0:    r = PT_LO_A;
          3'd1:    r = PT_HI_C;
          default: r = PT_HI_A;
        endcase
      end
      MODE_TOP: begin
        case (i)
          3'd0:    r = PT_HI_A;
          3'd1:    r = PT_LO_A;
          default: r = PT_LO_C;
        endcase
      end
      MODE_MID: begin
        case (i)
          3'd0:    r = PT_LO_A;
          3'd1:    r = PT_HI_C;
          3'd2:    r = PT_HI_A;
          3'd3:    r = PT_LO_A;
          3'd4:    r = PT_LO_C;
          default: r = PT_HI_C;
        endcase
      end
      default: r = PT_LO_A;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/uv_sphere_tessellator_core.sv @@
`default_nettype none
// Input: one index pair per cycle into the pipeline (angle setup, 32-stage CORDIC, scaling),
// taken only while the output patch register is empty or hands out its last vertex.
// Output: one vertex per cycle while out_ready is high, 3 per cap and 6 per middle band;
// the output patch register sets the sustained patch rate under a steady stream.
// Reset (rst, synchronous, active high) clears all valid bits and loads radius 1.0,
// count 16 and a zero center.
module uv_sphere_tessellator_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [uvst_pkg::IDX_W-1:0]       segment_index,
  input  logic [uvst_pkg::IDX_W-1:0]       band_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [uvst_pkg::CRD_W-1:0] vertex_x,
  output logic signed [uvst_pkg::CRD_W-1:0] vertex_y,
  output logic signed [uvst_pkg::CRD_W-1:0] vertex_z,
  output logic                             last_vertex
);
  import uvst_pkg::*;

  // ---------------- configuration registers ----------------
  logic [RAD_W-1:0]        sphere_radius;
  logic [CNT_W-1:0]        tessellation_count;
  logic signed [CRD_W-1:0] center_x;
  logic signed [CRD_W-1:0] center_y;
  logic signed [CRD_W-1:0] center_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius      <= RADIUS_RST;
      tessellation_count <= COUNT_RST;
      center_x           <= '0;
      center_y           <= '0;
      center_z           <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RADIUS: sphere_radius      <= cfg_data[RAD_W-1:0];
        REG_COUNT:  tessellation_count <= cfg_data[CNT_W-1:0];
        REG_CX:     center_x           <= $signed(cfg_data);
        REG_CY:     center_y           <= $signed(cfg_data);
        REG_CZ:     center_z           <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------- global pipeline advance ----------------
  // The whole pipe moves together; it holds only while a patch is still draining.
  logic       pv;
  patch_mode_t pmode;
  logic [2:0] pidx;
  logic       en;

  assign en       = !pv || (out_ready && last_vertex);
  assign in_ready = en;

  // ---------------- stage A: range checks, patch kind ----------------
  logic [CNT_W-1:0] p_m1;
  logic [CNT_W-1:0] p_m2;
  logic             in_ok;
  side_t            in_side;

  assign p_m1 = tessellation_count - CNT_W'(1);
  assign p_m2 = tessellation_count - CNT_W'(2);

  always_comb begin
    in_ok = (tessellation_count >= CNT_W'(3)) &&
            (tessellation_count <= CNT_W'(MAX_COUNT)) &&
            ({1'b0, segment_index} < tessellation_count) &&
            ({1'b0, band_index} <= p_m2);
    in_side.pole_lo = (band_index == '0);
    in_side.pole_hi = ({1'b0, band_index} == p_m2);
    if (in_side.pole_lo) in_side.mode = MODE_BOTTOM;
    else if (in_side.pole_hi) in_side.mode = MODE_TOP;
    else in_side.mode = MODE_MID;
  end

  logic             a_vld;
  logic [IDX_W-1:0] a_s;
  logic [IDX_W-1:0] a_b;
  side_t            a_side;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (en) a_vld <= in_valid && in_ok;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_s    <= segment_index;
      a_b    <= band_index;
      a_side <= in_side;
    end
  end

  // ---------------- stage B: angle = k*Q + (k*R + d/2) / d ----------------
  // 2^n * k / d split as k*floor(2^n/d) plus a small remainder division
  logic [CNT_W-1:0] bk [NUNIT];
  logic [CNT_W-1:0] bd [NUNIT];

  always_comb begin
    bk[0] = {1'b0, a_b};
    bk[1] = {1'b0, a_b} + CNT_W'(1);
    bk[2] = {1'b0, a_s};
    bk[3] = {1'b0, a_s} + CNT_W'(1);
    bd[0] = p_m1;
    bd[1] = p_m1;
    bd[2] = tessellation_count;
    bd[3] = tessellation_count;
  end

  logic              b_vld;
  side_t             b_side;
  logic [ANG_W-1:0]  b_kq  [NUNIT];
  logic [NUM_W-1:0]  b_num [NUNIT];
  logic [RCP_SH-1:0] b_rcp [NUNIT];

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (en) b_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    logic [2*CNT_W-1:0] t;
    if (en) begin
      b_side <= a_side;
      for (int u = 0; u < NUNIT; u++) begin
        if (u < 2) begin
          b_kq[u] <= ANG_W'(ANG_W'(bk[u]) * Q_LAT[bd[u]]);
          t = (2*CNT_W)'(bk[u]) * (2*CNT_W)'(R_LAT[bd[u]]) + (2*CNT_W)'(bd[u] >> 1);
        end else begin
          b_kq[u] <= ANG_W'(ANG_W'(bk[u]) * Q_COL[bd[u]]);
          t = (2*CNT_W)'(bk[u]) * (2*CNT_W)'(R_COL[bd[u]]) + (2*CNT_W)'(bd[u] >> 1);
        end
        b_num[u] <= NUM_W'(t);
        b_rcp[u] <= RCP[bd[u]];
      end
    end
  end

  // reciprocal divide of the small remainder, then latitude shift by -1/4 turn
  ang_vec_t c_ang;

  always_comb begin
    logic [NUM_W+RCP_SH-1:0] prod;
    logic [ANG_W-1:0]        a;
    for (int u = 0; u < NUNIT; u++) begin
      prod = (NUM_W+RCP_SH)'(b_num[u]) * (NUM_W+RCP_SH)'(b_rcp[u]);
      a    = b_kq[u] + ANG_W'(prod[NUM_W+RCP_SH-1:RCP_SH]);
      c_ang[u] = (u < 2) ? (a - QUARTER) : a;
    end
  end

  // ---------------- CORDIC sin/cos, four lanes ----------------
  logic    cd_vld;
  side_t   cd_side;
  cs_vec_t cd_cos;
  cs_vec_t cd_sin;

  uvst_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (b_vld),
    .in_side  (b_side),
    .in_ang   (c_ang),
    .out_vld  (cd_vld),
    .out_side (cd_side),
    .cos_val  (cd_cos),
    .sin_val  (cd_sin)
  );

  // ---------------- stage E: ring radius and height ----------------
  logic signed [RW-1:0] r_s;
  assign r_s = $signed(RW'(sphere_radius));

  logic                 e_vld;
  patch_mode_t          e_mode;
  logic signed [RW-1:0] e_ring [2];
  logic signed [RW-1:0] e_h    [2];
  logic signed [CW-1:0] e_ct   [2];
  logic signed [CW-1:0] e_st   [2];

  always_ff @(posedge clk) begin
    if (rst) e_vld <= 1'b0;
    else if (en) e_vld <= cd_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_mode <= cd_side.mode;
      for (int j = 0; j < 2; j++) begin
        e_ct[j]   <= $signed(cd_cos[2+j]);
        e_st[j]   <= $signed(cd_sin[2+j]);
      end
      // poles are exact
      if (cd_side.pole_lo) begin
        e_ring[0] <= '0;
        e_h[0]    <= -r_s;
      end else begin
        e_ring[0] <= mul_q30(r_s, $signed(cd_cos[0]));
        e_h[0]    <= mul_q30(r_s, $signed(cd_sin[0]));
      end
      if (cd_side.pole_hi) begin
        e_ring[1] <= '0;
        e_h[1]    <= r_s;
      end else begin
        e_ring[1] <= mul_q30(r_s, $signed(cd_cos[1]));
        e_h[1]    <= mul_q30(r_s, $signed(cd_sin[1]));
      end
    end
  end

  // ---------------- stage F: rotate about Y ----------------
  logic                 f_vld;
  patch_mode_t          f_mode;
  logic signed [RW-1:0] f_x [NPT];
  logic signed [RW-1:0] f_z [NPT];
  logic signed [RW-1:0] f_h [2];

  always_ff @(posedge clk) begin
    if (rst) f_vld <= 1'b0;
    else if (en) f_vld <= e_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_mode <= e_mode;
      for (int j = 0; j < 2; j++) begin
        f_h[j] <= e_h[j];
        for (int k = 0; k < 2; k++) begin
          f_x[2*j+k] <= mul_q30(e_ring[j], e_ct[k]);
          f_z[2*j+k] <= mul_q30(e_ring[j], e_st[k]);
        end
      end
    end
  end

  // ---------------- output patch register: center offset, saturation ----------------
  logic [CRD_W-1:0] px [NPT];
  logic [CRD_W-1:0] pz [NPT];
  logic [CRD_W-1:0] py [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pv   <= 1'b0;
      pidx <= '0;
    end else if (en) begin
      pv   <= f_vld;
      pidx <= '0;
    end else if (out_ready) begin
      pidx <= pidx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pmode <= f_mode;
      for (int q = 0; q < NPT; q++) begin
        px[q] <= sat32((CRD_W+2)'(center_x) + (CRD_W+2)'(f_x[q]));
        pz[q] <= sat32((CRD_W+2)'(center_z) - (CRD_W+2)'(f_z[q]));
      end
      for (int j = 0; j < 2; j++) begin
        py[j] <= sat32((CRD_W+2)'(center_y) + (CRD_W+2)'(f_h[j]));
      end
    end
  end

  // vertex order within the patch
  logic [1:0] sel;
  assign sel         = pt_sel(pmode, pidx);
  assign out_valid   = pv;
  assign vertex_x    = $signed(px[sel]);
  assign vertex_y    = $signed(py[sel[1]]);
  assign vertex_z    = $signed(pz[sel]);
  assign last_vertex = (pidx == ((pmode == MODE_MID) ? LAST_MID : LAST_CAP));

  // ---------------- checks ----------------
  a_cap_len: assert property (@(posedge clk) disable iff (rst)
    (pv && pmode != MODE_MID) |-> (pidx <= LAST_CAP))
    else $error("cap patch index past its third vertex");

  a_step: assert property (@(posedge clk) disable iff (rst)
    (pv && out_ready && !last_vertex) |=> (pv && pidx == $past(pidx) + 3'd1))
    else $error("vertex index did not advance by one");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!en) |=> ($stable(b_vld) && $stable(e_vld) && $stable(f_vld)))
    else $error("pipeline moved while stalled");

  a_bad_count: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && tessellation_count < CNT_W'(3)) |=> !a_vld)
    else $error("item accepted with too small a count");

endmodule
`default_nettype wire

@@ rtl/uvst_cordic.sv @@
`default_nettype none
module uvst_cordic (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  uvst_pkg::side_t    in_side,
  input  uvst_pkg::ang_vec_t in_ang,
  output logic              out_vld,
  output uvst_pkg::side_t    out_side,
  output uvst_pkg::cs_vec_t  cos_val,
  output uvst_pkg::cs_vec_t  sin_val
);
  import uvst_pkg::*;

  logic signed [CW-1:0]    x    [ITERS+1][NUNIT];
  logic signed [CW-1:0]    y    [ITERS+1][NUNIT];
  logic signed [ANG_W-1:0] z    [ITERS+1][NUNIT];
  logic [1:0]              quad [ITERS+1][NUNIT];
  logic                    vld  [ITERS+1];
  side_t                   side [ITERS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= ITERS; i++) vld[i] <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
      for (int i = 0; i < ITERS; i++) vld[i+1] <= vld[i];
      out_vld <= vld[ITERS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int u = 0; u < NUNIT; u++) begin
        x[0][u]    <= CORDIC_GAIN;
        y[0][u]    <= '0;
        z[0][u]    <= {2'b00, in_ang[u][ANG_W-3:0]};
        quad[0][u] <= in_ang[u][ANG_W-1:ANG_W-2];
      end
      for (int i = 0; i < ITERS; i++) begin
        side[i+1] <= side[i];
        for (int u = 0; u < NUNIT; u++) begin
          quad[i+1][u] <= quad[i][u];
          if (!z[i][u][ANG_W-1]) begin
            x[i+1][u] <= x[i][u] - (y[i][u] >>> i);
            y[i+1][u] <= y[i][u] + (x[i][u] >>> i);
            z[i+1][u] <= z[i][u] - $signed(ATAN_TAB[i]);
          end else begin
            x[i+1][u] <= x[i][u] + (y[i][u] >>> i);
            y[i+1][u] <= y[i][u] - (x[i][u] >>> i);
            z[i+1][u] <= z[i][u] + $signed(ATAN_TAB[i]);
          end
        end
      end
      // quadrant fold-back
      out_side <= side[ITERS];
      for (int u = 0; u < NUNIT; u++) begin
        case (quad[ITERS][u])
          2'd0: begin
            cos_val[u] <= x[ITERS][u];
            sin_val[u] <= y[ITERS][u];
          end
          2'd1: begin
            cos_val[u] <= -y[ITERS][u];
            sin_val[u] <= x[ITERS][u];
          end
          2'd2: begin
            cos_val[u] <= -x[ITERS][u];
            sin_val[u] <= -y[ITERS][u];
          end
          default: begin
            cos_val[u] <= y[ITERS][u];
            sin_val[u] <= -x[ITERS][u];
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/tb_uv_sphere_tessellator_core.sv @@
`default_nettype none
module tb_uv_sphere_tessellator_core;
  import uvst_pkg::*;

  // One vertex as it leaves the block.
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } vertex_t;

  // Predicts the vertices of each patch and matches them against what comes out.
  class patch_scoreboard;
    vertex_t     pending_q[$];
    int          errors;
    int          patches;
    int          vertices;
    logic [23:0] radius;
    logic [6:0]  count;
    longint      cx, cy, cz;

    function new();
      radius = 24'h010000;
      count  = 7'd16;
      cx = 0; cy = 0; cz = 0;
      errors = 0; patches = 0; vertices = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] d);
      case (idx)
        REG_RADIUS: radius = d[23:0];
        REG_COUNT:  count = d[6:0];
        REG_CX:     cx = longint'(signed'(d));
        REG_CY:     cy = longint'(signed'(d));
        REG_CZ:     cz = longint'(signed'(d));
        default: ;
      endcase
    endfunction

    function longint q30_scale(longint a, longint b);
      return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    // 30-step rotation CORDIC on the residual angle, then whole quarter turns.
    function void cos_sin(logic [31:0] ang, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = longint'(ang[29:0]);
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
        end
      end
      case (ang[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function vertex_t sphere_vertex(int lat, int col);
      vertex_t v;
      longint ring, height, ct, st, cp, sp;
      longint unsigned p, num;
      logic [31:0] a_col, a_lat;
      p = longint'(count);
      num = (longint'(col) << 32) + p / 2;
      a_col = 32'(num / p);
      if (lat == 0) begin
        ring = 0; height = -longint'(radius);
      end else if (lat == int'(p) - 1) begin
        ring = 0; height = longint'(radius);
      end else begin
        num = (longint'(lat) << 31) + (p - 1) / 2;
        a_lat = 32'(num / (p - 1)) - 32'h40000000;
        cos_sin(a_lat, cp, sp);
        ring = q30_scale(longint'(radius), cp);
        height = q30_scale(longint'(radius), sp);
      end
      cos_sin(a_col, ct, st);
      v.x = clamp32(cx + q30_scale(ring, ct));
      v.y = clamp32(cy + height);
      v.z = clamp32(cz - q30_scale(ring, st));
      v.last = 1'b0;
      return v;
    endfunction

    // Accepted index pair: queue the patch's vertices in winding order.
    function void note_patch(int s, int b);
      int p, n;
      int lat[6], col[6];
      vertex_t v;
      p = int'(count);
      if (p < 3 || p > MAX_COUNT || s >= p || b > p - 2) return;
      if (b == 0) begin
        lat = '{0, 1, 1, 0, 0, 0}; col = '{s, s + 1, s, 0, 0, 0}; n = 3;
      end else if (b == p - 2) begin
        lat = '{b + 1, b, b, 0, 0, 0}; col = '{s, s, s + 1, 0, 0, 0}; n = 3;
      end else begin
        lat = '{b, b + 1, b + 1, b, b, b + 1};
        col = '{s, s + 1, s, s, s + 1, s + 1};
        n = 6;
      end
      for (int k = 0; k < n; k++) begin
        v = sphere_vertex(lat[k], col[k]);
        v.last = (k == n - 1);
        pending_q = {pending_q, v};
      end
      patches++;
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d (vertex %0d)", what, got, want, vertices);
    endtask

    task check_vertex(vertex_t got);
      vertex_t want;
      if (pending_q.size() == 0) begin
        report("unexpected vertex, x", longint'(got.x), 0);
        return;
      end
      want = pending_q.pop_front();
      if (got.x !== want.x) report("vertex_x", longint'(got.x), longint'(want.x));
      if (got.y !== want.y) report("vertex_y", longint'(got.y), longint'(want.y));
      if (got.z !== want.z) report("vertex_z", longint'(got.z), longint'(want.z));
      if (got.last !== want.last) report("last_vertex", longint'(got.last), longint'(want.last));
      vertices++;
    endtask
  endclass

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;   // comfortably past the time the pipeline takes to empty

  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic [IDX_W-1:0] segment_index, band_index;
  logic out_valid, out_ready;
  logic signed [31:0] vertex_x, vertex_y, vertex_z;
  logic last_vertex;

  patch_scoreboard sb;
  int idle_cycles;
  int burst_left;
  int stall_mode, stall_tick;
  int sent_items;

  uv_sphere_tessellator_core u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .segment_index(segment_index), .band_index(band_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
    .last_vertex(last_vertex)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure: each time stall_tick reaches a multiple of 64, pick a new stall pattern
  // (always ready, coin flip, or mostly stalled).
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Output monitor: one vertex transaction per handshake.
  always @(posedge clk) begin
    vertex_t got;
    if (!rst && out_valid && out_ready) begin
      got.x = vertex_x; got.y = vertex_y; got.z = vertex_z; got.last = last_vertex;
      sb.check_vertex(got);
    end
  end

  // Watchdog: too long without any transaction on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog expired, %0d vertices pending", sb.pending_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Register write; only issued while the block is idle.
  task write_reg(cfg_reg_t idx, logic [31:0] d);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task set_sphere(logic [23:0] r, logic [6:0] p, logic [31:0] x, logic [31:0] y,
                  logic [31:0] z);
    write_reg(REG_RADIUS, 32'(r));
    write_reg(REG_COUNT, 32'(p));
    write_reg(REG_CX, x);
    write_reg(REG_CY, y);
    write_reg(REG_CZ, z);
  endtask

  // Sender with bursts and random gaps; valid holds until the transaction.
  task send_patch(int s, int b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    burst_left--;
    in_valid = 1'b1;
    segment_index = s[5:0];
    band_index = b[5:0];
    do @(posedge clk); while (!in_ready);
    sb.note_patch(s, b);
    sent_items++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Hold off until every queued vertex has come out, then let the pipe empty.
  task drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly valid patches; now and then any 6-bit pair at all.
  task random_patches(int n);
    int p;
    p = int'(sb.count);
    for (int i = 0; i < n; i++) begin
      if (p < 3 || p > MAX_COUNT || $urandom_range(0, 9) == 0)
        send_patch($urandom_range(0, 63), $urandom_range(0, 63));
      else if ($urandom_range(0, 4) == 0)
        send_patch($urandom_range(0, p - 1), ($urandom_range(0, 1) != 0) ? p - 2 : 0);
      else
        send_patch($urandom_range(0, p - 1), $urandom_range(0, p - 2));
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; segment_index = '0; band_index = '0;
    out_ready = 1'b0;
    idle_cycles = 0; burst_left = 0; stall_mode = 0; stall_tick = 0; sent_items = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: bottom cap, top cap with the full-turn column, middle band,
    // and indices out of range.
    send_patch(0, 0);
    send_patch(15, 14);
    send_patch(7, 7);
    send_patch(0, 1);
    send_patch(16, 3);
    send_patch(3, 15);
    send_patch(63, 63);
    send_patch(15, 0);
    random_patches(50);
    drain();

    // Smallest count, largest radius, centers that force saturation both ways.
    set_sphere(24'hffffff, 7'd3, 32'h7fffffff, 32'h80000000, 32'h80000000);
    send_patch(0, 0);
    send_patch(2, 1);
    send_patch(1, 0);
    send_patch(3, 0);
    send_patch(0, 2);
    random_patches(30);
    drain();

    // Largest count, zero radius collapses every vertex onto the center.
    set_sphere(24'h000000, 7'd64, 32'h00010000, 32'hfffe0000, 32'h7fff0000);
    send_patch(63, 62);
    send_patch(63, 0);
    send_patch(0, 31);
    random_patches(20);
    drain();

    // Counts that produce nothing at all.
    write_reg(REG_COUNT, 32'd2);
    random_patches(6);
    drain();
    write_reg(REG_COUNT, 32'd0);
    random_patches(4);
    drain();
    write_reg(REG_COUNT, 32'd65);
    random_patches(4);
    drain();
    write_reg(REG_COUNT, 32'd127);
    random_patches(4);
    drain();

    // Large sphere at the largest count, random center.
    set_sphere(24'h800000 | 24'($urandom_range(0, 24'h7fffff)), 7'd64,
               $urandom, $urandom, $urandom);
    random_patches(100);
    drain();

    write_reg(REG_COUNT, 32'd4);
    write_reg(REG_RADIUS, 32'h00018000);
    random_patches(30);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_sphere(24'($urandom), 7'($urandom_range(3, 64)),
                 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000),
                 $urandom, 32'($urandom_range(0, 32'h0003ffff)));
      random_patches(40);
      drain();
    end

    if (sb.pending_q.size() != 0) sb.report("vertices never produced", sb.pending_q.size(), 0);
    $display("covered %0d index pairs, %0d patches, %0d vertices checked",
             sent_items, sb.patches, sb.vertices);
    $display("counts 0..127 incl. caps, middle bands, saturation, zero radius");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
